// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the LED blink and pulse controller.
// No dependencies. Include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge, with checking held off in reset.
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition in one cycle implies a consequence in the next.
`define ASSERT_NEXT(lbl, clk, rst, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/lbp_pkg.sv =====
// Types and constants for the LED blink and pulse controller.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package lbp_pkg;

  // Width of the duration fields of a command
  localparam int unsigned DUR_BITS = 16;

  // Register index of the lit polarity register
  localparam logic REG_LIT_POLARITY = 1'b0;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_PULSE = 2'd2,
    CMD_BLINK = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE  = 2'd0,
    MODE_FIXED = 2'd1,
    MODE_PULSE = 2'd2,
    MODE_BLINK = 2'd3
  } mode_t;

  // One result item
  typedef struct packed {
    logic  pin_level;
    logic  lit;
    mode_t mode;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lbp_core.sv =====
// Command decoder and LED state registers: applies one command per transfer
// and forms its result. Depends on lbp_pkg.
`default_nettype none

module lbp_core import lbp_pkg::*; #(
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                accept,
  input  wire logic [1:0]          cmd,
  input  wire logic                level,
  input  wire logic [DUR_BITS-1:0] pulse_time,
  input  wire logic [DUR_BITS-1:0] on_time,
  input  wire logic [DUR_BITS-1:0] off_time,
  input  wire logic signed [7:0]   cycle_count,
  input  wire logic                lit_polarity,
  output result_t                  result
);

  mode_t                mode_reg, mode_reg_next;
  logic                 lit_reg, lit_reg_next;
  logic [TIME_BITS-1:0] elapsed, elapsed_next;
  logic [TIME_BITS-1:0] pulse_len, pulse_len_next;
  logic [TIME_BITS-1:0] on_len, on_len_next;
  logic [TIME_BITS-1:0] off_len, off_len_next;
  logic [6:0]           cycles_left, cycles_left_next;
  logic                 temporary, temporary_next;

  logic [TIME_BITS-1:0] pulse_clip, on_clip, off_clip;
  logic [TIME_BITS-1:0] elapsed_inc;
  logic                 cc_positive;

  // Saturate incoming durations to the timer width
  if (TIME_BITS >= DUR_BITS) begin : g_wide
    assign pulse_clip = TIME_BITS'(pulse_time);
    assign on_clip    = TIME_BITS'(on_time);
    assign off_clip   = TIME_BITS'(off_time);
  end else begin : g_narrow
    assign pulse_clip = (|pulse_time[DUR_BITS-1:TIME_BITS]) ? '1 : pulse_time[TIME_BITS-1:0];
    assign on_clip    = (|on_time[DUR_BITS-1:TIME_BITS])    ? '1 : on_time[TIME_BITS-1:0];
    assign off_clip   = (|off_time[DUR_BITS-1:TIME_BITS])   ? '1 : off_time[TIME_BITS-1:0];
  end

  // Saturating elapsed count for one tick
  assign elapsed_inc = (&elapsed) ? elapsed : elapsed + TIME_BITS'(1);
  assign cc_positive = !cycle_count[7] && (|cycle_count[6:0]);

  // Hold the state registers; advance them on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg    <= MODE_IDLE;
      lit_reg     <= 1'b0;
      elapsed     <= '0;
      pulse_len   <= '0;
      on_len      <= '0;
      off_len     <= '0;
      cycles_left <= '0;
      temporary   <= 1'b0;
    end else if (accept) begin
      mode_reg    <= mode_reg_next;
      lit_reg     <= lit_reg_next;
      elapsed     <= elapsed_next;
      pulse_len   <= pulse_len_next;
      on_len      <= on_len_next;
      off_len     <= off_len_next;
      cycles_left <= cycles_left_next;
      temporary   <= temporary_next;
    end
  end

  // Next state for the command on the input
  always_comb begin
    mode_reg_next    = mode_reg;
    lit_reg_next     = lit_reg;
    elapsed_next     = elapsed;
    pulse_len_next   = pulse_len;
    on_len_next      = on_len;
    off_len_next     = off_len;
    cycles_left_next = cycles_left;
    temporary_next   = temporary;
    unique case (cmd_t'(cmd))
      CMD_TICK: begin
        if (mode_reg == MODE_PULSE) begin
          if (elapsed_inc >= pulse_len) begin
            mode_reg_next  = MODE_IDLE;
            lit_reg_next   = 1'b0;
            temporary_next = 1'b0;
            elapsed_next   = '0;
          end else begin
            elapsed_next = elapsed_inc;
          end
        end else if (mode_reg == MODE_BLINK) begin
          if (lit_reg) begin
            if (elapsed_inc >= on_len) begin
              lit_reg_next = 1'b0;
              elapsed_next = '0;
            end else begin
              elapsed_next = elapsed_inc;
            end
          end else if (elapsed_inc >= off_len) begin
            lit_reg_next = 1'b1;
            elapsed_next = '0;
            // Count down a temporary blink on each dark-to-lit change
            if (temporary) begin
              if (cycles_left <= 7'd1) begin
                cycles_left_next = '0;
                mode_reg_next    = MODE_IDLE;
                lit_reg_next     = 1'b0;
                temporary_next   = 1'b0;
              end else begin
                cycles_left_next = cycles_left - 7'd1;
              end
            end
          end else begin
            elapsed_next = elapsed_inc;
          end
        end
      end
      CMD_SET: begin
        mode_reg_next    = MODE_FIXED;
        lit_reg_next     = level;
        temporary_next   = 1'b0;
        elapsed_next     = '0;
        cycles_left_next = '0;
      end
      CMD_PULSE: begin
        if (mode_reg != MODE_PULSE) begin
          mode_reg_next    = MODE_PULSE;
          lit_reg_next     = 1'b1;
          temporary_next   = 1'b0;
          elapsed_next     = '0;
          cycles_left_next = '0;
          pulse_len_next   = pulse_clip;
        end
      end
      CMD_BLINK: begin
        if (mode_reg != MODE_BLINK) begin
          mode_reg_next    = MODE_BLINK;
          lit_reg_next     = 1'b1;
          temporary_next   = cc_positive;
          elapsed_next     = '0;
          cycles_left_next = cc_positive ? cycle_count[6:0] : 7'd0;
          on_len_next      = on_clip;
          off_len_next     = off_clip;
        end
      end
      default: begin
        mode_reg_next = mode_reg;
      end
    endcase
  end

  // Result taken after the command is applied
  always_comb begin
    result.lit       = lit_reg_next;
    result.mode      = mode_reg_next;
    result.pin_level = lit_reg_next ? lit_polarity : ~lit_polarity;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lbp_out_fifo.sv =====
// Two-entry result queue between the command core and the output channel.
// Depends on lbp_pkg.
`default_nettype none

module lbp_out_fifo import lbp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  result_t   push_data,
  output logic      full,
  output logic      out_valid,
  input  wire logic out_stall,
  output result_t   out_data
);

  result_t    entries [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign full      = (count == 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = entries[rd_ptr];

  // Store a result on each push
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Advance the pointers and the fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/led_blink_pulse_controller_top.sv =====
// Top level of the LED blink and pulse controller: APB register, command core
// and result queue. Depends on lbp_pkg, lbp_core, lbp_out_fifo, assert_macros.svh.
//
//   Channel  Direction  Handshake             Payload
//   in       input      in_valid / in_stall   cmd level pulse_time on_time off_time cycle_count
//   out      output     out_valid / out_stall pin_level lit mode
//   apb      input      psel penable pready   paddr pwrite pwdata prdata
//
// One command per cycle while in_stall is low; its result is queued at the transfer and,
// with the queue empty, offered on the cycle after. The core state is registered on each
// transfer; the two-entry result queue sets the rate under output stall: in_stall rises once two results wait.
// Reset is synchronous; no clearing pass follows it.
// pready is always high.
`default_nettype none

module led_blink_pulse_controller_top import lbp_pkg::*; #(
  parameter int unsigned TIME_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          cmd,
  input  wire logic                level,
  input  wire logic [DUR_BITS-1:0] pulse_time,
  input  wire logic [DUR_BITS-1:0] on_time,
  input  wire logic [DUR_BITS-1:0] off_time,
  input  wire logic signed [7:0]   cycle_count,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     pin_level,
  output logic                     lit,
  output logic [1:0]               mode,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [2:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  logic    lit_polarity;
  logic    in_accept;
  result_t core_result;
  result_t out_data;

  assign pready    = 1'b1;
  assign in_accept = in_valid && !in_stall;

  // Write the lit polarity register
  always_ff @(posedge clk) begin
    if (rst) begin
      lit_polarity <= 1'b1;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LIT_POLARITY)) begin
      lit_polarity <= pwdata[0];
    end
  end

  // Read back the register
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_LIT_POLARITY) begin
      prdata[0] = lit_polarity;
    end
  end

  lbp_core #(
    .TIME_BITS(TIME_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_accept),
    .cmd         (cmd),
    .level       (level),
    .pulse_time  (pulse_time),
    .on_time     (on_time),
    .off_time    (off_time),
    .cycle_count (cycle_count),
    .lit_polarity(lit_polarity),
    .result      (core_result)
  );

  lbp_out_fifo u_out_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (in_accept),
    .push_data(core_result),
    .full     (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  assign pin_level = out_data.pin_level;
  assign lit       = out_data.lit;
  assign mode      = out_data.mode;

`include "assert_macros.svh"

  // Input stalls only while results are waiting
  `ASSERT_AT(a_stall_needs_results, clk, rst, !in_stall || out_valid, "in_stall without results")
  // An idle result is always dark
  `ASSERT_AT(a_idle_dark, clk, rst, !(out_valid && mode == MODE_IDLE) || !lit, "idle but lit")
  // A pulse result is always lit
  `ASSERT_AT(a_pulse_lit, clk, rst, !(out_valid && mode == MODE_PULSE) || lit, "pulse but dark")
  // A transfer with the queue empty offers a result next cycle
  `ASSERT_NEXT(a_result_follows, clk, rst, in_accept && !out_valid, out_valid, "result lost")

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the LED blink and pulse controller: a queue-fed command
// driver with a built-in behavioural model, a result monitor, and APB register writes.
// Depends on lbp_pkg and led_blink_pulse_controller_top.
`timescale 1ns / 100ps

module tb_top import lbp_pkg::*;;

  localparam logic [2:0] LIT_POLARITY_ADDR = 3'(4 * REG_LIT_POLARITY);
  localparam int unsigned MAX_GAP = 14;
  localparam int unsigned HOLD_CYCLES = 150;

  typedef struct {
    cmd_t               op;
    logic               lvl;
    logic [15:0]        pulse_ms;
    logic [15:0]        on_ms;
    logic [15:0]        off_ms;
    logic signed [7:0]  cycles;
    int unsigned        gap;
  } led_cmd_t;

  // Clock, reset and block ports
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] cmd = CMD_TICK;
  logic level = 1'b0;
  logic [DUR_BITS-1:0] pulse_time = '0;
  logic [DUR_BITS-1:0] on_time = '0;
  logic [DUR_BITS-1:0] off_time = '0;
  logic signed [7:0] cycle_count = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic pin_level;
  logic lit;
  logic [1:0] mode;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Commands waiting to be offered, and results waiting to arrive
  led_cmd_t cmd_queue[$];
  result_t  pending_results[$];

  // Shadow LED state, at reset values
  logic              led_active = 1'b1;
  mode_t             led_mode = MODE_IDLE;
  logic              led_lit = 1'b0;
  logic [15:0]       led_elapsed = '0;
  logic [15:0]       led_pulse_len = '0;
  logic [15:0]       led_on_len = '0;
  logic [15:0]       led_off_len = '0;
  int                led_cycles_left = 0;
  bit                led_temporary = 1'b0;

  int          errors = 0;
  int          results_seen = 0;
  int          cmds_sent[4] = '{default: 0};
  led_cmd_t    cur_cmd;
  int unsigned tx_wait = 0;
  int unsigned rx_wait = 0;
  bit          rx_quiet = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;

  always #6 clk = ~clk;

  led_blink_pulse_controller_top dut (.*);

  // Drop the LED to idle and dark
  function automatic void led_go_idle();
    led_mode = MODE_IDLE;
    led_lit = 1'b0;
    led_temporary = 1'b0;
    led_elapsed = '0;
  endfunction

  // Apply one command to the shadow state and return the result it produces
  function automatic result_t led_response(led_cmd_t c);
    result_t r;
    case (c.op)
      CMD_TICK: begin
        if (led_mode == MODE_PULSE || led_mode == MODE_BLINK) begin
          if (led_elapsed != '1) led_elapsed++;
          if (led_mode == MODE_PULSE) begin
            if (led_elapsed >= led_pulse_len) led_go_idle();
          end else if (led_lit) begin
            if (led_elapsed >= led_on_len) begin
              led_lit = 1'b0;
              led_elapsed = '0;
            end
          end else if (led_elapsed >= led_off_len) begin
            led_lit = 1'b1;
            led_elapsed = '0;
            // Count down a temporary blink on each dark-to-lit change
            if (led_temporary) begin
              led_cycles_left--;
              if (led_cycles_left <= 0) begin
                led_cycles_left = 0;
                led_go_idle();
              end
            end
          end
        end
      end
      CMD_SET: begin
        led_go_idle();
        led_mode = MODE_FIXED;
        led_cycles_left = 0;
        led_lit = c.lvl;
      end
      CMD_PULSE: begin
        if (led_mode != MODE_PULSE) begin
          led_go_idle();
          led_mode = MODE_PULSE;
          led_cycles_left = 0;
          led_pulse_len = c.pulse_ms;
          led_lit = 1'b1;
        end
      end
      default: begin
        if (led_mode != MODE_BLINK) begin
          led_go_idle();
          led_mode = MODE_BLINK;
          if (c.cycles > 0) begin
            led_cycles_left = c.cycles;
            led_temporary = 1'b1;
          end else begin
            led_cycles_left = 0;
          end
          led_on_len = c.on_ms;
          led_off_len = c.off_ms;
          led_lit = 1'b1;
        end
      end
    endcase
    r.pin_level = led_lit ? led_active : ~led_active;
    r.lit = led_lit;
    r.mode = led_mode;
    return r;
  endfunction

  function automatic led_cmd_t make_cmd(cmd_t op, logic lvl, logic [15:0] pulse_ms,
                                        logic [15:0] on_ms, logic [15:0] off_ms,
                                        logic signed [7:0] cycles);
    led_cmd_t c;
    c.op = op;
    c.lvl = lvl;
    c.pulse_ms = pulse_ms;
    c.on_ms = on_ms;
    c.off_ms = off_ms;
    c.cycles = cycles;
    c.gap = $urandom_range(0, MAX_GAP);
    return c;
  endfunction

  // Mostly short durations so that pulses and blinks expire; now and then any value
  function automatic logic [15:0] rand_duration();
    if ($urandom_range(0, 15) == 0) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(0, 6));
  endfunction

  // Offer queued commands; predict each one on its transfer
  always @(posedge clk) begin : command_driver
    led_cmd_t c;
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid) begin
        pending_results.push_back(led_response(cur_cmd));
        cmds_sent[cur_cmd.op]++;
      end
      if (tx_wait != 0) begin
        in_valid <= 1'b0;
        tx_wait--;
      end else if (cmd_queue.size() != 0) begin
        c = cmd_queue.pop_front();
        cur_cmd = c;
        tx_wait = c.gap;
        cmd <= c.op;
        level <= c.lvl;
        pulse_time <= c.pulse_ms;
        on_time <= c.on_ms;
        off_time <= c.off_ms;
        cycle_count <= c.cycles;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Count down the long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Check each result transfer against the oldest prediction, then pick the next stall
  always @(posedge clk) begin : result_monitor
    int unsigned wait_n;
    result_t want;
    if (rst) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      wait_n = rx_wait;
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: pin_level %0b lit %0b mode %0d", pin_level, lit, mode);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (pin_level !== want.pin_level) begin
            $error("pin_level: expected %0b, actual %0b", want.pin_level, pin_level);
            errors++;
          end
          if (lit !== want.lit) begin
            $error("lit: expected %0b, actual %0b", want.lit, lit);
            errors++;
          end
          if (mode !== want.mode) begin
            $error("mode: expected %0d, actual %0d", want.mode, mode);
            errors++;
          end
        end
        results_seen++;
        if (results_seen % 32 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
        wait_n = rx_quiet ? 0 : $urandom_range(0, MAX_GAP);
      end else if (wait_n != 0) begin
        wait_n--;
      end
      rx_wait = wait_n;
      out_stall <= (wait_n != 0) || (hold_left != 0);
    end
  end

  // Wait until every command has gone and every result has come back
  task automatic drain();
    do @(posedge clk);
    while (cmd_queue.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Write the lit polarity over APB, then read it back
  task automatic write_lit_polarity(input logic val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= LIT_POLARITY_ADDR;
    pwdata <= {31'b0, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    led_active = val;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'b0, val}) begin
      $error("prdata: expected %0h, actual %0h", {31'b0, val}, prdata);
      errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Queue a batch of random commands, mostly ticks, and run it to completion
  task automatic random_phase(input int n, input bit hold);
    led_cmd_t c;
    cmd_t op;
    bit quiet;
    int pick;
    logic signed [7:0] cycles;
    quiet = 1'b0;
    for (int i = 0; i < n; i++) begin
      if (i % 30 == 0) quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      op = CMD_TICK;
      if (pick >= 55) op = CMD_SET;
      if (pick >= 65) op = CMD_PULSE;
      if (pick >= 80) op = CMD_BLINK;
      if ($urandom_range(0, 7) == 0) cycles = 8'($urandom_range(0, 255));
      else cycles = 8'($urandom_range(0, 8)) - 8'sd3;
      c = make_cmd(op, 1'($urandom_range(0, 1)), rand_duration(), rand_duration(),
                   rand_duration(), cycles);
      if (quiet || (hold && i < 40)) c.gap = 0;
      cmd_queue.push_back(c);
    end
    // Hold the output off for a long stretch while the sender keeps offering
    if (hold) begin
      @(posedge clk);
      hold_req <= 1'b1;
      @(posedge clk);
      hold_req <= 1'b0;
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed commands under the reset polarity
    cmd_queue.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));        // idle tick
    cmd_queue.push_back(make_cmd(CMD_SET, 1, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));        // fixed tick
    cmd_queue.push_back(make_cmd(CMD_SET, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_PULSE, 0, 16'd0, 0, 0, 0));   // zero length pulse
    cmd_queue.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_PULSE, 0, 16'd2, 0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_PULSE, 1, 16'd100, 0, 0, 0)); // ignored while pulsing
    cmd_queue.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));        // pulse expires
    cmd_queue.push_back(make_cmd(CMD_BLINK, 0, 0, 16'd0, 16'd0, 8'sd0)); // endless, toggles
    cmd_queue.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_BLINK, 0, 0, 16'd9, 16'd9, 8'sd5)); // ignored
    cmd_queue.push_back(make_cmd(CMD_SET, 1, 0, 0, 0, 0));         // set ends the blink
    cmd_queue.push_back(make_cmd(CMD_BLINK, 0, 0, 16'd1, 16'd0, 8'sd1)); // one cycle only
    cmd_queue.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));        // temporary blink ends
    cmd_queue.push_back(make_cmd(CMD_BLINK, 1, 16'hFFFF, 16'hFFFF, 16'hFFFF, -8'sd128));
    cmd_queue.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_PULSE, 1, 16'hFFFF, 0, 0, 0)); // pulse from blink
    cmd_queue.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_BLINK, 0, 0, 16'd0, 16'd1, 8'sd127));
    cmd_queue.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    cmd_queue.push_back(make_cmd(CMD_TICK, 0, 0, 0, 0, 0));
    drain();

    // Random batches under alternating polarities
    write_lit_polarity(1'b0);
    random_phase(200, 1'b0);
    write_lit_polarity(1'b1);
    random_phase(230, 1'b1);
    write_lit_polarity(1'b0);
    random_phase(200, 1'b0);

    repeat (20) @(posedge clk);
    $display("Ran %0d commands (%0d ticks, %0d sets, %0d pulses, %0d blinks)",
             cmds_sent[CMD_TICK] + cmds_sent[CMD_SET] + cmds_sent[CMD_PULSE]
             + cmds_sent[CMD_BLINK], cmds_sent[CMD_TICK], cmds_sent[CMD_SET],
             cmds_sent[CMD_PULSE], cmds_sent[CMD_BLINK]);
    $display("under both pin polarities; %0d results checked, %0d mismatches",
             results_seen, errors);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
